[design/ntpf_pkg.sv]
package ntpf_pkg;

  // Default neighbour table depth
  localparam int TABLE_DEPTH_DEF = 32;

  // Fixed field widths
  localparam int ADDR_W   = 16;
  localparam int TYPE_W   = 8;
  localparam int SIG_W    = 8;
  localparam int ACT_W    = 4;
  localparam int OIDX_W   = 5;
  localparam int OCNT_W   = 6;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 16;

  // Strength used for list-entry adds: always passes the threshold
  localparam logic signed [SIG_W-1:0] LIST_ADD_STRENGTH = 8'sd127;

  // Operations
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Result action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ADDED     = 4'd0,
    ACT_KNOWN     = 4'd1,
    ACT_WEAK      = 4'd2,
    ACT_FULL      = 4'd3,
    ACT_NO_MATCH  = 4'd4,
    ACT_IGNORED   = 4'd5,
    ACT_VALUES    = 4'd6,
    ACT_CLOCK     = 4'd7,
    ACT_NOT_NEIGH = 4'd8,
    ACT_UNKNOWN   = 4'd9,
    ACT_CLEARED   = 4'd10
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_OWN_ADDR    = 3'd0,
    CFG_MIN_SIGNAL  = 3'd1,
    CFG_TYPE_DISC   = 3'd2,
    CFG_TYPE_NEIGH  = 3'd3,
    CFG_TYPE_VALUES = 3'd4,
    CFG_TYPE_CLOCK  = 3'd5
  } cfg_reg_t;

  // Configuration reset values
  localparam logic [ADDR_W-1:0]        OWN_ADDR_RST    = 16'd0;
  localparam logic signed [SIG_W-1:0]  MIN_SIGNAL_RST  = 8'sh80;
  localparam logic [TYPE_W-1:0]        TYPE_DISC_RST   = 8'd0;
  localparam logic [TYPE_W-1:0]        TYPE_NEIGH_RST  = 8'd1;
  localparam logic [TYPE_W-1:0]        TYPE_VALUES_RST = 8'd2;
  localparam logic [TYPE_W-1:0]        TYPE_CLOCK_RST  = 8'd3;

  // Request payload
  typedef struct packed {
    logic                     operation;
    logic [ADDR_W-1:0]        source_address;
    logic [TYPE_W-1:0]        packet_type;
    logic signed [SIG_W-1:0]  signal_strength;
    logic [ADDR_W-1:0]        list_entry;
    logic                     entry_last;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OIDX_W-1:0] neighbour_index;
    logic [OCNT_W-1:0] neighbour_count;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } dp_stat_t;

endpackage

[design/ntpf_ram.sv]
module ntpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/ntpf_ctrl.sv]
module ntpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ntpf_pkg::dp_stat_t  stat,
  output ntpf_pkg::ctrl_cmd_t cmd
);

  import ntpf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[design/ntpf_dp.sv]
module ntpf_dp #(
  parameter int TABLE_DEPTH = ntpf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ntpf_pkg::ctrl_cmd_t           cmd,
  output ntpf_pkg::dp_stat_t            stat,
  input  ntpf_pkg::in_item_t            in_data,
  output logic                          out_valid,
  output ntpf_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [ntpf_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [ntpf_pkg::CFG_D_W-1:0]  cfg_data
);

  import ntpf_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  // Configuration registers
  logic [ADDR_W-1:0]       own_addr_r;
  logic signed [SIG_W-1:0] min_signal_r;
  logic [TYPE_W-1:0]       type_disc_r, type_neigh_r, type_values_r, type_clock_r;

  // Table state
  logic [CW-1:0] count_r, count_nxt;
  logic          ended_r, ended_nxt;

  // Request and scan registers
  in_item_t      item_r;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] found_idx_r, found_idx_nxt;

  // Result registers
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  // Table memory
  logic              ram_we;
  logic [ADDR_W-1:0] ram_rdata;
  logic              hit;
  logic              more;

  ntpf_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(item_r.source_address),
    .raddr(scan_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r    <= OWN_ADDR_RST;
      min_signal_r  <= MIN_SIGNAL_RST;
      type_disc_r   <= TYPE_DISC_RST;
      type_neigh_r  <= TYPE_NEIGH_RST;
      type_values_r <= TYPE_VALUES_RST;
      type_clock_r  <= TYPE_CLOCK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDR:    own_addr_r    <= cfg_data;
        CFG_MIN_SIGNAL:  min_signal_r  <= cfg_data[SIG_W-1:0];
        CFG_TYPE_DISC:   type_disc_r   <= cfg_data[TYPE_W-1:0];
        CFG_TYPE_NEIGH:  type_neigh_r  <= cfg_data[TYPE_W-1:0];
        CFG_TYPE_VALUES: type_values_r <= cfg_data[TYPE_W-1:0];
        CFG_TYPE_CLOCK:  type_clock_r  <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Serial search: one read issued and one compare per cycle
  assign more = (scan_idx_r < count_r);
  assign hit  = rd_pend_r && (ram_rdata == item_r.source_address);
  assign stat.scan_done = hit || (!rd_pend_r && !more);

  always_comb begin
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    rd_pend_nxt   = rd_pend_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    if (cmd.load) begin
      scan_idx_nxt = '0;
      rd_pend_nxt  = 1'b0;
      found_nxt    = 1'b0;
    end else if (cmd.scan_en) begin
      if (hit) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp_idx_r;
      end
      rd_pend_nxt = more && !hit;
      cmp_idx_nxt = scan_idx_r[AW-1:0];
      if (more) scan_idx_nxt = scan_idx_r + 1'b1;
    end
  end

  // Classification and table update
  always_comb begin
    logic                    is_disc;
    logic                    is_neigh;
    logic                    add_req;
    logic signed [SIG_W-1:0] add_str;
    logic [ACT_W-1:0]        act;
    logic [AW-1:0]           idx;
    logic [AW+OIDX_W-1:0]    idx_ext;
    logic [CW+OCNT_W-1:0]    cnt_ext;

    is_disc  = (item_r.packet_type == type_disc_r);
    is_neigh = !is_disc && (item_r.packet_type == type_neigh_r);
    add_req  = 1'b0;
    add_str  = is_disc ? item_r.signal_strength : LIST_ADD_STRENGTH;
    act      = ACT_UNKNOWN;
    idx      = '0;
    ram_we   = 1'b0;
    count_nxt = count_r;
    ended_nxt = ended_r;

    if (item_r.operation == OP_CLEAR) begin
      act       = ACT_CLEARED;
      count_nxt = '0;
      ended_nxt = 1'b0;
    end else if (is_disc) begin
      ended_nxt = 1'b0;
      add_req   = 1'b1;
    end else if (is_neigh) begin
      if (ended_r) begin
        act = ACT_IGNORED;
      end else if (item_r.list_entry == '0) begin
        ended_nxt = 1'b1;
        act       = ACT_IGNORED;
      end else if (item_r.list_entry == own_addr_r) begin
        add_req = 1'b1;
      end else begin
        act = ACT_NO_MATCH;
      end
      if (item_r.entry_last) ended_nxt = 1'b0;
    end else begin
      ended_nxt = 1'b0;
      if (!found_r) begin
        act = ACT_NOT_NEIGH;
      end else begin
        idx = found_idx_r;
        if (item_r.packet_type == type_values_r) act = ACT_VALUES;
        else if (item_r.packet_type == type_clock_r) act = ACT_CLOCK;
        else act = ACT_UNKNOWN;
      end
    end

    // Add the source to the table
    if (add_req) begin
      if (item_r.source_address == '0) begin
        act = ACT_NOT_NEIGH;
      end else if (add_str < min_signal_r) begin
        act = ACT_WEAK;
      end else if (found_r) begin
        act = ACT_KNOWN;
        idx = found_idx_r;
      end else if (count_r >= FULL_CNT) begin
        act = ACT_FULL;
      end else begin
        act       = ACT_ADDED;
        idx       = count_r[AW-1:0];
        ram_we    = cmd.finish;
        count_nxt = count_r + 1'b1;
      end
    end

    idx_ext = {{OIDX_W{1'b0}}, idx};
    cnt_ext = {{OCNT_W{1'b0}}, count_nxt};
    out_data_nxt.action          = act;
    out_data_nxt.neighbour_index = idx_ext[OIDX_W-1:0];
    out_data_nxt.neighbour_count = cnt_ext[OCNT_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ended_r     <= 1'b0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        count_r <= count_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_idx_r <= found_idx_nxt;
    if (cmd.finish) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/neighbour_table_packet_filter.sv]
// A taken request runs a serial search of the stored neighbours until a match or
// the last stored entry (one entry read and compared per cycle from the table
// memory), then its result shows on out_valid. A new request is taken only once
// the last one is through; busy drops as the result shows.
// Reset (rst_n low, synchronous) empties the table, clears the list state and
// loads the register defaults; no clearing pass is needed. Results cannot stall.
module neighbour_table_packet_filter #(
  parameter int TABLE_DEPTH = ntpf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ntpf_pkg::in_item_t            in_data,
  output logic                          out_valid,
  output ntpf_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [ntpf_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [ntpf_pkg::CFG_D_W-1:0]  cfg_data
);

  import ntpf_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ntpf_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  ntpf_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule

[verif/tb_neighbour_table_packet_filter.sv]
`timescale 1ns / 100ps

module tb_neighbour_table_packet_filter;
  import ntpf_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RST_CYCLES  = 8;
  localparam int N_PHASES    = 14;
  localparam int PHASE_ITEMS = 128;
  localparam int TAIL_CYCLES = TABLE_DEPTH_DEF + 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TIMEOUT_NS  = 20_000_000;
  localparam int MAX_REPORTS = 10;

  // DUT ports
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      start     = 1'b0;
  logic      busy;
  in_item_t  in_data   = '0;
  logic      out_valid;
  out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_D_W-1:0]  cfg_data  = '0;

  neighbour_table_packet_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the neighbour table and the register file
  logic [ADDR_W-1:0]       peer_addr [TABLE_DEPTH_DEF];
  int unsigned             peer_count;
  bit                      list_closed;
  logic [ADDR_W-1:0]       own_addr;
  logic signed [SIG_W-1:0] min_sig;
  logic [TYPE_W-1:0]       code_disc;
  logic [TYPE_W-1:0]       code_neigh;
  logic [TYPE_W-1:0]       code_values;
  logic [TYPE_W-1:0]       code_clock;

  out_item_t         pending_results [$];
  logic [ADDR_W-1:0] peer_pool [$];
  int                mismatch_count = 0;
  bit                sender_quiet   = 1'b0;

  // Opening requests, some with the result written out by hand
  typedef struct {
    in_item_t  req;
    bit        known;
    out_item_t res;
  } stim_row_t;

  stim_row_t opening_rows [$];

  // ---------------------------------------------------------------------------
  // Classifier model
  // ---------------------------------------------------------------------------

  // Slot of a stored neighbour, -1 if absent; address zero never matches
  function automatic int find_peer(input logic [ADDR_W-1:0] a);
    if (a == '0) return -1;
    for (int i = 0; i < peer_count; i++)
      if (peer_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic action_t admit_peer(input logic [ADDR_W-1:0] a,
                                         input logic signed [SIG_W-1:0] s,
                                         output int idx);
    int hit;
    idx = 0;
    if (a == '0) return ACT_NOT_NEIGH;
    if (s < min_sig) return ACT_WEAK;
    hit = find_peer(a);
    if (hit >= 0) begin
      idx = hit;
      return ACT_KNOWN;
    end
    if (peer_count >= TABLE_DEPTH_DEF) return ACT_FULL;
    peer_addr[peer_count] = a;
    idx = peer_count;
    peer_count++;
    return ACT_ADDED;
  endfunction

  function automatic out_item_t classify_packet(input in_item_t r);
    out_item_t res;
    action_t   act;
    int        idx;
    int        hit;
    idx = 0;
    if (r.operation == OP_CLEAR) begin
      foreach (peer_addr[i]) peer_addr[i] = '0;
      peer_count  = 0;
      list_closed = 1'b0;
      act = ACT_CLEARED;
    end else if (r.packet_type == code_disc) begin
      list_closed = 1'b0;
      act = admit_peer(r.source_address, r.signal_strength, idx);
    end else if (r.packet_type == code_neigh) begin
      // list walk: the first zero entry closes it until entry_last or a non-list packet
      if (list_closed)
        act = ACT_IGNORED;
      else if (r.list_entry == '0) begin
        list_closed = 1'b1;
        act = ACT_IGNORED;
      end else if (r.list_entry == own_addr)
        act = admit_peer(r.source_address, LIST_ADD_STRENGTH, idx);
      else
        act = ACT_NO_MATCH;
      if (r.entry_last) list_closed = 1'b0;
    end else begin
      hit = find_peer(r.source_address);
      list_closed = 1'b0;
      if (hit < 0)
        act = ACT_NOT_NEIGH;
      else begin
        idx = hit;
        if (r.packet_type == code_values)
          act = ACT_VALUES;
        else if (r.packet_type == code_clock)
          act = ACT_CLOCK;
        else
          act = ACT_UNKNOWN;
      end
    end
    res.action          = act;
    res.neighbour_index = idx[OIDX_W-1:0];
    res.neighbour_count = peer_count[OCNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t mk(input logic op, input logic [ADDR_W-1:0] src,
                                  input logic [TYPE_W-1:0] ptype,
                                  input logic signed [SIG_W-1:0] sig,
                                  input logic [ADDR_W-1:0] entry, input logic last);
    in_item_t r;
    r.operation       = op;
    r.source_address  = src;
    r.packet_type     = ptype;
    r.signal_strength = sig;
    r.list_entry      = entry;
    r.entry_last      = last;
    return r;
  endfunction

  function automatic void row(input in_item_t req, input bit known = 1'b0,
                              input action_t act = ACT_ADDED, input int idx = 0,
                              input int cnt = 0);
    stim_row_t s;
    s.req   = req;
    s.known = known;
    s.res.action          = act;
    s.res.neighbour_index = idx[OIDX_W-1:0];
    s.res.neighbour_count = cnt[OCNT_W-1:0];
    opening_rows.push_back(s);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t r;
    r.operation       = 1'($urandom);
    r.source_address  = 16'($urandom);
    r.packet_type     = 8'($urandom);
    r.signal_strength = 8'($urandom);
    r.list_entry      = 16'($urandom);
    r.entry_last      = 1'($urandom);
    return r;
  endfunction

  // Mostly addresses from the phase pool, now and then zero or a stranger
  function automatic logic [ADDR_W-1:0] pick_source();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 8) return 16'($urandom);
    return peer_pool[$urandom_range(0, peer_pool.size() - 1)];
  endfunction

  // Hold the request until taken, log its prediction, maybe idle a while
  task automatic send_request(input in_item_t r, input bit known, input out_item_t res);
    out_item_t predicted;
    in_data <= r;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = classify_packet(r);
    pending_results.push_back(known ? res : predicted);
    if (!sender_quiet && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_D_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    @(posedge clk);
    case (ix)
      CFG_OWN_ADDR:    own_addr    = val;
      CFG_MIN_SIGNAL:  min_sig     = val[SIG_W-1:0];
      CFG_TYPE_DISC:   code_disc   = val[TYPE_W-1:0];
      CFG_TYPE_NEIGH:  code_neigh  = val[TYPE_W-1:0];
      CFG_TYPE_VALUES: code_values = val[TYPE_W-1:0];
      CFG_TYPE_CLOCK:  code_clock  = val[TYPE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register settings per phase: extremes, random values and coinciding type codes
  task automatic program_phase(input int p);
    logic [TYPE_W-1:0]       t0, t1, t2, t3, shared;
    logic [ADDR_W-1:0]       own_v;
    logic signed [SIG_W-1:0] min_v;
    case (p % 4)
      0:       own_v = '1;
      1:       own_v = 16'($urandom_range(1, 16'hFFFE));
      2:       own_v = '0;
      default: own_v = 16'($urandom);
    endcase
    case (p % 5)
      0:       min_v = 8'sh80;
      1:       min_v = 8'sh7F;
      2:       min_v = 8'($urandom);
      3:       min_v = 8'sh00;
      default: min_v = 8'shF0;
    endcase
    shared = 8'($urandom);
    if (p == 3) begin
      // every code the same: discovery wins
      {t0, t1, t2, t3} = {4{shared}};
    end else if (p == 6) begin
      t0 = 8'($urandom);
      {t1, t2, t3} = {3{shared}};
    end else if (p == 9) begin
      t0 = 8'($urandom);
      t1 = 8'($urandom);
      {t2, t3} = {2{shared}};
    end else if (p % 2 == 0) begin
      {t0, t1, t2, t3} = {TYPE_DISC_RST, TYPE_NEIGH_RST, TYPE_VALUES_RST, TYPE_CLOCK_RST};
    end else begin
      {t0, t1, t2, t3} = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    end
    write_reg(CFG_OWN_ADDR, own_v);
    write_reg(CFG_MIN_SIGNAL, {8'($urandom), min_v});
    write_reg(CFG_TYPE_DISC, {8'($urandom), t0});
    write_reg(CFG_TYPE_NEIGH, {8'($urandom), t1});
    write_reg(CFG_TYPE_VALUES, {8'($urandom), t2});
    write_reg(CFG_TYPE_CLOCK, {8'($urandom), t3});
    // unmapped indexes must leave the registers alone
    if (p == 0)
      for (int k = int'(CFG_TYPE_CLOCK) + 1; k < (1 << CFG_IX_W); k++)
        write_reg(k[CFG_IX_W-1:0], 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Random packet mix; flood turns most of it into discoveries to fill the table
  task automatic run_traffic(input int n, input int pool_n, input bit flood);
    in_item_t          r;
    logic [ADDR_W-1:0] src;
    int                sent;
    int                pick;
    int                len;
    sent = 0;
    peer_pool.delete();
    repeat (pool_n) peer_pool.push_back(16'($urandom_range(1, 16'hFFFF)));
    while (sent < n) begin
      pick = $urandom_range(0, 199);
      r = rand_item();
      r.operation = OP_PACKET;
      r.source_address = pick_source();
      if (pick == 0) begin
        r.operation = OP_CLEAR;
        send_request(r, 1'b0, '0);
        sent++;
      end else if (pick < (flood ? 170 : 64)) begin
        r.packet_type = code_disc;
        if ($urandom_range(0, 9) == 0)
          r.signal_strength = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
        else if ($urandom_range(0, 5) == 0)
          r.signal_strength = $urandom_range(0, 1) ? min_sig : min_sig - 8'sd1;
        send_request(r, 1'b0, '0);
        sent++;
      end else if (pick < 120) begin
        // neighbour list, one entry per request, framing broken now and then
        src = r.source_address;
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          r = rand_item();
          r.operation      = OP_PACKET;
          r.source_address = src;
          r.packet_type    = code_neigh;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: r.list_entry = own_addr;
            4:          r.list_entry = '0;
            5:          r.list_entry = pick_source();
            default: ;
          endcase
          r.entry_last = (j == len - 1);
          if ($urandom_range(0, 9) == 0) r.entry_last = ~r.entry_last;
          send_request(r, 1'b0, '0);
          sent++;
        end
      end else begin
        if (pick < 150)
          r.packet_type = code_values;
        else if (pick < 175)
          r.packet_type = code_clock;
        else if (pick >= 190)
          r = rand_item();
        send_request(r, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string why, input out_item_t want, input out_item_t got);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t: %s: expected action=%0d idx=%0d count=%0d, got action=%0d idx=%0d count=%0d",
               $realtime, why, want.action, want.neighbour_index, want.neighbour_count,
               got.action, got.neighbour_index, got.neighbour_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0)
        flag_mismatch("result with no request pending", '0, out_data);
      else begin
        want = pending_results.pop_front();
        if (want.action !== out_data.action ||
            want.neighbour_index !== out_data.neighbour_index ||
            want.neighbour_count !== out_data.neighbour_count)
          flag_mismatch("result mismatch", want, out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int guard;
    in_item_t r;

    // shadow state after reset
    foreach (peer_addr[i]) peer_addr[i] = '0;
    peer_count  = 0;
    list_closed = 1'b0;
    own_addr    = OWN_ADDR_RST;
    min_sig     = MIN_SIGNAL_RST;
    code_disc   = TYPE_DISC_RST;
    code_neigh  = TYPE_NEIGH_RST;
    code_values = TYPE_VALUES_RST;
    code_clock  = TYPE_CLOCK_RST;

    // directed part, run with the register defaults
    row(mk(OP_PACKET, 16'h1234, TYPE_VALUES_RST, 8'sh00, 16'h0000, 1'b1), 1, ACT_NOT_NEIGH, 0, 0);
    row(mk(OP_PACKET, 16'h0000, TYPE_DISC_RST, 8'sh7F, 16'h0000, 1'b1), 1, ACT_NOT_NEIGH, 0, 0);
    row(mk(OP_PACKET, 16'hFFFF, TYPE_DISC_RST, 8'sh80, 16'h0000, 1'b1), 1, ACT_ADDED, 0, 1);
    row(mk(OP_PACKET, 16'hFFFF, TYPE_DISC_RST, 8'sh7F, 16'hFFFF, 1'b0), 1, ACT_KNOWN, 0, 1);
    row(mk(OP_PACKET, 16'h0001, TYPE_DISC_RST, 8'sh00, 16'h0000, 1'b1), 1, ACT_ADDED, 1, 2);
    row(mk(OP_PACKET, 16'h8000, TYPE_DISC_RST, 8'shFF, 16'h0000, 1'b1));
    row(mk(OP_PACKET, 16'hFFFF, TYPE_VALUES_RST, 8'sh00, 16'h0000, 1'b1), 1, ACT_VALUES, 0, 3);
    row(mk(OP_PACKET, 16'h0001, TYPE_CLOCK_RST, 8'sh00, 16'h0000, 1'b1), 1, ACT_CLOCK, 1, 3);
    row(mk(OP_PACKET, 16'h8000, 8'hFF, 8'sh00, 16'h0000, 1'b1), 1, ACT_UNKNOWN, 2, 3);
    row(mk(OP_PACKET, 16'h5555, 8'hFF, 8'sh00, 16'h0000, 1'b1), 1, ACT_NOT_NEIGH, 0, 3);
    row(mk(OP_PACKET, 16'h0000, TYPE_CLOCK_RST, 8'sh00, 16'h0000, 1'b1), 1, ACT_NOT_NEIGH, 0, 3);
    // list handling: zero entry closes the list even with own address zero
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'hFFFF, 1'b0), 1, ACT_NO_MATCH, 0, 3);
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'h0000, 1'b0), 1, ACT_IGNORED, 0, 3);
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'h0001, 1'b0));
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'h1234, 1'b1), 1, ACT_IGNORED, 0, 3);
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'h1234, 1'b1));
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'h0000, 1'b0));
    // a packet of another type reopens the list
    row(mk(OP_PACKET, 16'hFFFF, TYPE_VALUES_RST, 8'sh00, 16'h0000, 1'b0));
    row(mk(OP_PACKET, 16'hAAAA, TYPE_NEIGH_RST, 8'sh00, 16'h7777, 1'b1));
    row(mk(OP_CLEAR, 16'h0000, 8'h00, 8'sh00, 16'h0000, 1'b0), 1, ACT_CLEARED, 0, 0);
    row(mk(OP_PACKET, 16'hFFFF, TYPE_VALUES_RST, 8'sh00, 16'h0000, 1'b1), 1, ACT_NOT_NEIGH, 0, 0);
    row(mk(OP_CLEAR, 16'hFFFF, 8'hFF, 8'shFF, 16'hFFFF, 1'b1), 1, ACT_CLEARED, 0, 0);

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      send_request(opening_rows[i].req, opening_rows[i].known, opening_rows[i].res);

    // random phases, each under its own register settings
    for (int p = 0; p < N_PHASES; p++) begin
      start <= 1'b0;
      wait_idle();
      program_phase(p);
      sender_quiet = (p == 7);
      if ($urandom_range(0, 1)) begin
        r = rand_item();
        r.operation = OP_CLEAR;
        send_request(r, 1'b0, '0);
      end
      if (p == 5 || p == 12)
        run_traffic(PHASE_ITEMS, 48, 1'b1);
      else
        run_traffic(PHASE_ITEMS, $urandom_range(4, 60), 1'b0);
    end

    // drain and settle
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
